### rtl/hci_pkg.sv
// Package: shared types, codes and constants of the host coupler interface.
`default_nettype none
package hci_pkg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [11:0] func_code;
        logic        channel_full;
        logic [11:0] channel_word;
        logic [11:0] upline_length;
        logic        upline_is_pru;
        logic [15:0] level7_length;
        logic [7:0]  unused_bits;
        logic        buffer_present;
        logic [10:0] buffer_address;
        logic [7:0]  buffer_data;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] channel_out;
        logic        channel_out_valid;
        logic        channel_taken;
        logic        disconnect_after;
        logic [3:0]  notify;
        logic [7:0]  regulation_level;
        logic [11:0] downline_length;
        logic [7:0]  buffer_byte;
    } result_t;

    typedef enum logic [1:0] {
        PS_INIT,
        PS_IDLE,
        PS_UPLINE,
        PS_DOWNLINE
    } proto_state_t;

    typedef enum logic [1:0] {
        CS_READY,
        CS_FETCH,
        CS_SHOW
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
        logic load_byte;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_read;
    } dp_stat_t;

    localparam logic [2:0] MODE_FUNCTION = 3'd0;
    localparam logic [2:0] MODE_CHANNEL  = 3'd1;
    localparam logic [2:0] MODE_UPLINE   = 3'd2;
    localparam logic [2:0] MODE_DOWNLINE = 3'd3;
    localparam logic [2:0] MODE_TICK     = 3'd4;
    localparam logic [2:0] MODE_BUF_WR   = 3'd5;
    localparam logic [2:0] MODE_BUF_RD   = 3'd6;

    localparam logic [8:0] FN_NONE        = 9'o000;
    localparam logic [8:0] FN_INPUT_DATA  = 9'o003;
    localparam logic [8:0] FN_READ_NPU    = 9'o004;
    localparam logic [8:0] FN_READ_CPL    = 9'o005;
    localparam logic [8:0] FN_READ_ORDER  = 9'o006;
    localparam logic [8:0] FN_READ_ZERO   = 9'o007;
    localparam logic [8:0] FN_TAKE_A      = 9'o010;
    localparam logic [8:0] FN_TAKE_B      = 9'o011;
    localparam logic [8:0] FN_OUTPUT_DATA = 9'o014;
    localparam logic [8:0] FN_TAKE_C      = 9'o015;
    localparam logic [8:0] FN_WRITE_ORDER = 9'o016;
    localparam logic [8:0] FN_SEL_A       = 9'o040;
    localparam logic [8:0] FN_SEL_B       = 9'o100;
    localparam logic [8:0] FN_CLEAR       = 9'o200;
    localparam logic [8:0] FN_SEL_C       = 9'o400;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_DECLINED = 2'd1;
    localparam logic [1:0] ST_NO_SEL   = 2'd2;

    localparam logic [3:0] NT_NONE       = 4'd0;
    localparam logic [3:0] NT_UPLINE     = 4'd1;
    localparam logic [3:0] NT_DL_DONE    = 4'd2;
    localparam logic [3:0] NT_DL_ABORT   = 4'd3;
    localparam logic [3:0] NT_SERVICE    = 4'd4;
    localparam logic [3:0] NT_HIGH       = 4'd5;
    localparam logic [3:0] NT_LOW        = 4'd6;
    localparam logic [3:0] NT_RETRY      = 4'd7;
    localparam logic [3:0] NT_REGULATION = 4'd8;

    localparam logic [3:0] ORD_SERVICE    = 4'h1;
    localparam logic [3:0] ORD_HIGH       = 4'h2;
    localparam logic [3:0] ORD_LOW        = 4'h3;
    localparam logic [3:0] ORD_RETRY      = 4'h4;
    localparam logic [3:0] ORD_REGULATION = 4'h5;
    localparam logic [3:0] ORD_INIT_ACK   = 4'h6;

    localparam logic [15:0] NS_IDLE      = 16'o001;
    localparam logic [15:0] NS_DL_READY  = 16'o002;
    localparam logic [15:0] NS_DL_NOBUF  = 16'o003;
    localparam logic [15:0] NS_UL_SHORT  = 16'o004;
    localparam logic [15:0] NS_UL_LONG   = 16'o005;
    localparam logic [15:0] NS_UL_PRU    = 16'o006;
    localparam logic [15:0] NS_INIT_DONE = 16'o010;

    localparam logic [11:0] STATUS_LOADED  = 12'h004;
    localparam logic [15:0] LAST_BYTE_MARK = 16'o4000;
    localparam logic [11:0] SHORT_BLOCK    = 12'd256;

    localparam logic [7:0]  CFG_IDLE_TICKS = 8'd0;
    localparam logic [7:0]  CFG_INIT_COUNT = 8'd1;
    localparam logic [31:0] IDLE_TICKS_RST = 32'd100000;
    localparam logic [3:0]  INIT_COUNT_RST = 4'd4;

    // ceil(bits/3840) = floor((bits+3839)/256/15); /15 by reciprocal 4370/65536
    localparam logic [19:0] PRU_ROUND = 20'd3839;
    localparam logic [12:0] RECIP_15  = 13'd4370;
    localparam logic [5:0]  PRU_MAX   = 6'd63;

endpackage
`default_nettype wire

### rtl/hci_if.sv
// Interfaces: item, result and configuration channels.
`default_nettype none
interface hci_item_if;
    logic          valid;
    logic          ready;
    hci_pkg::item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface hci_result_if;
    logic            valid;
    logic            ready;
    hci_pkg::result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface hci_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/hci_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none
module hci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/hci_ctrl.sv
// Controller: sequences accept, buffer fetch and result hand-off.
`default_nettype none
module hci_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    output      logic               out_valid,
    input  wire logic               out_ready,
    input  wire hci_pkg::dp_stat_t  stat,
    output      hci_pkg::ctrl_cmd_t cmd
);
    import hci_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_READY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_READY:
            begin
                if (in_valid)
                begin
                    state_next = stat.need_read ? CS_FETCH : CS_SHOW;
                end
            end
            CS_FETCH:
            begin
                state_next = CS_SHOW;
            end
            CS_SHOW:
            begin
                if (out_ready)
                begin
                    state_next = CS_READY;
                end
            end
            default:
            begin
                state_next = CS_READY;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd.exec      = 1'b0;
        cmd.load_byte = 1'b0;
        case (state_reg)
            CS_READY:
            begin
                in_ready = 1'b1;
                cmd.exec = in_valid;
            end
            CS_FETCH:
            begin
                cmd.load_byte = 1'b1;
            end
            CS_SHOW:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end
endmodule
`default_nettype wire

### rtl/hci_dp.sv
// Datapath: protocol state, status words, byte buffer and result register.
`default_nettype none
module hci_dp #(
    parameter int BUFFER_BYTES = 2048
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hci_pkg::item_t     item,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire hci_pkg::ctrl_cmd_t cmd,
    output      hci_pkg::dp_stat_t  stat,
    output      hci_pkg::result_t   result
);
    import hci_pkg::*;

    localparam int AW  = $clog2(BUFFER_BYTES);
    localparam int TCB = $clog2(BUFFER_BYTES + 1);
    localparam int CW  = (TCB > 12) ? TCB : 12;

    proto_state_t  proto_reg, proto_next;
    logic [3:0]    init_rem_reg, init_rem_next;
    logic [11:0]   cpl_status_reg, cpl_status_next;
    logic [15:0]   npu_status_reg, npu_status_next;
    logic [11:0]   order_reg, order_next;
    logic [8:0]    active_fn_reg, active_fn_next;
    logic [CW-1:0] xfer_cnt_reg, xfer_cnt_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic          held_reg, held_next;
    logic [31:0]   tick_reg, tick_next;
    logic [31:0]   last_status_reg, last_status_next;
    logic [CW-1:0] blk_len_reg, blk_len_next;
    logic [31:0]   idle_ticks_reg;
    logic [3:0]    init_count_reg;

    result_t res_reg, res_next;
    logic    byte_chan_reg, byte_chan_next;
    logic    byte_buf_reg, byte_buf_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr, ptr_adv;
    logic [7:0]    ram_wdata, ram_rdata;

    logic [8:0]    fn;
    logic          addr_ok, put_en;
    logic [15:0]   put_val;
    logic [18:0]   pru_total, pru_bits;
    logic [19:0]   pru_round;
    logic [24:0]   pru_prod;
    logic [8:0]    pru_q;
    logic [5:0]    pru_cnt;
    logic [CW-1:0] xfer_inc;

    hci_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign fn       = item.func_code[8:0];
    assign addr_ok  = {21'd0, item.buffer_address} < 32'(BUFFER_BYTES);
    assign ptr_adv  = (ptr_reg == AW'(BUFFER_BYTES - 1)) ? '0 : ptr_reg + 1'b1;
    assign xfer_inc = xfer_cnt_reg + 1'b1;

    assign pru_total = {item.level7_length, 3'b000};
    assign pru_bits  = pru_total - 19'(item.unused_bits);
    assign pru_round = {1'b0, pru_bits} + PRU_ROUND;
    assign pru_prod  = 25'(pru_round[19:8]) * 25'(RECIP_15);
    assign pru_q     = pru_prod[24:16];

    always_comb
    begin
        if ({11'd0, item.unused_bits} >= pru_total || pru_q == 9'd0)
        begin
            pru_cnt = 6'd1;
        end
        else if (pru_q > 9'(PRU_MAX))
        begin
            pru_cnt = PRU_MAX;
        end
        else
        begin
            pru_cnt = pru_q[5:0];
        end
    end

    always_comb
    begin
        stat.need_read = 1'b0;
        if (item.mode == MODE_BUF_RD)
        begin
            stat.need_read = addr_ok;
        end
        else if (item.mode == MODE_CHANNEL && active_fn_reg == FN_INPUT_DATA)
        begin
            stat.need_read = !item.channel_full && xfer_cnt_reg != '0;
        end
    end

    always_comb
    begin
        ram_raddr = (item.mode == MODE_BUF_RD) ? AW'(item.buffer_address) : ptr_reg;
        ram_we    = 1'b0;
        ram_waddr = AW'(item.buffer_address);
        ram_wdata = item.buffer_data;
        if (cmd.exec)
        begin
            if (item.mode == MODE_BUF_WR)
            begin
                ram_we = addr_ok;
            end
            else if (item.mode == MODE_CHANNEL && active_fn_reg == FN_OUTPUT_DATA
                     && item.channel_full && xfer_cnt_reg < CW'(BUFFER_BYTES))
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = item.channel_word[7:0];
            end
        end
    end

    always_comb
    begin
        proto_next       = proto_reg;
        init_rem_next    = init_rem_reg;
        cpl_status_next  = cpl_status_reg;
        npu_status_next  = npu_status_reg;
        order_next       = order_reg;
        active_fn_next   = active_fn_reg;
        xfer_cnt_next    = xfer_cnt_reg;
        ptr_next         = ptr_reg;
        held_next        = held_reg;
        tick_next        = tick_reg;
        last_status_next = last_status_reg;
        blk_len_next     = blk_len_reg;
        res_next         = res_reg;
        byte_chan_next   = byte_chan_reg;
        byte_buf_next    = byte_buf_reg;
        put_en           = 1'b0;
        put_val          = '0;

        if (cmd.load_byte)
        begin
            if (byte_chan_reg)
            begin
                res_next.channel_out = res_reg.channel_out | {8'd0, ram_rdata};
            end
            if (byte_buf_reg)
            begin
                res_next.buffer_byte = ram_rdata;
            end
        end

        if (cmd.exec)
        begin
            res_next       = '0;
            byte_chan_next = 1'b0;
            byte_buf_next  = 1'b0;
            case (item.mode)
                MODE_FUNCTION:
                begin
                    active_fn_next = fn;
                    case (fn)
                        FN_READ_CPL:
                        begin
                            if (proto_reg == PS_INIT)
                            begin
                                put_en = 1'b1;
                                if (init_rem_reg != 4'd0)
                                begin
                                    init_rem_next = init_rem_reg - 1'b1;
                                    put_val       = NS_INIT_DONE;
                                end
                                else
                                begin
                                    proto_next = PS_IDLE;
                                    put_val    = NS_IDLE;
                                end
                            end
                            else if (proto_reg == PS_IDLE
                                     && (tick_reg - last_status_reg) > idle_ticks_reg)
                            begin
                                put_en  = 1'b1;
                                put_val = NS_IDLE;
                            end
                        end
                        FN_INPUT_DATA, FN_OUTPUT_DATA:
                        begin
                            if (!held_reg)
                            begin
                                proto_next      = PS_IDLE;
                                xfer_cnt_next   = '0;
                                active_fn_next  = FN_NONE;
                                res_next.status = ST_DECLINED;
                            end
                            else
                            begin
                                ptr_next      = '0;
                                xfer_cnt_next = (fn == FN_INPUT_DATA) ? blk_len_reg : '0;
                            end
                        end
                        FN_READ_NPU, FN_READ_ORDER, FN_READ_ZERO,
                        FN_TAKE_A, FN_TAKE_B, FN_TAKE_C:
                        begin
                            active_fn_next = fn;
                        end
                        FN_WRITE_ORDER:
                        begin
                            proto_next = PS_IDLE;
                            put_en     = 1'b1;
                            put_val    = NS_IDLE;
                        end
                        FN_CLEAR:
                        begin
                            proto_next       = PS_INIT;
                            init_rem_next    = init_count_reg;
                            cpl_status_next  = '0;
                            npu_status_next  = '0;
                            order_next       = '0;
                            xfer_cnt_next    = '0;
                            ptr_next         = '0;
                            held_next        = 1'b0;
                            last_status_next = '0;
                            blk_len_next     = '0;
                        end
                        FN_SEL_A, FN_SEL_B, FN_SEL_C:
                        begin
                            active_fn_next  = active_fn_reg;
                            res_next.status = ST_NO_SEL;
                        end
                        default:
                        begin
                            active_fn_next  = active_fn_reg;
                            res_next.status = ST_DECLINED;
                        end
                    endcase
                end
                MODE_CHANNEL:
                begin
                    case (active_fn_reg)
                        FN_READ_NPU:
                        begin
                            res_next.channel_out       = npu_status_reg;
                            res_next.channel_out_valid = 1'b1;
                            cpl_status_next = cpl_status_reg & ~STATUS_LOADED;
                            npu_status_next = '0;
                        end
                        FN_READ_CPL:
                        begin
                            res_next.channel_out       = {4'd0, cpl_status_reg};
                            res_next.channel_out_valid = 1'b1;
                        end
                        FN_READ_ORDER:
                        begin
                            res_next.channel_out       = {4'd0, order_reg};
                            res_next.channel_out_valid = 1'b1;
                        end
                        FN_INPUT_DATA:
                        begin
                            if (!item.channel_full && xfer_cnt_reg != '0)
                            begin
                                res_next.channel_out_valid = 1'b1;
                                byte_chan_next = 1'b1;
                                ptr_next       = ptr_adv;
                                xfer_cnt_next  = xfer_cnt_reg - 1'b1;
                                if (xfer_cnt_reg == CW'(1))
                                begin
                                    res_next.channel_out      = LAST_BYTE_MARK;
                                    res_next.disconnect_after = 1'b1;
                                    res_next.notify           = NT_UPLINE;
                                    active_fn_next = FN_NONE;
                                    proto_next     = PS_IDLE;
                                end
                            end
                        end
                        FN_OUTPUT_DATA:
                        begin
                            if (item.channel_full)
                            begin
                                res_next.channel_taken = 1'b1;
                                if (xfer_cnt_reg < CW'(BUFFER_BYTES))
                                begin
                                    ptr_next      = ptr_adv;
                                    xfer_cnt_next = xfer_inc;
                                    if (item.channel_word[11])
                                    begin
                                        blk_len_next    = xfer_inc;
                                        active_fn_next  = FN_NONE;
                                        proto_next      = PS_IDLE;
                                        res_next.notify = NT_DL_DONE;
                                        res_next.downline_length = xfer_inc[11:0];
                                    end
                                    else if (xfer_inc >= CW'(BUFFER_BYTES))
                                    begin
                                        active_fn_next  = FN_NONE;
                                        proto_next      = PS_IDLE;
                                        res_next.notify = NT_DL_ABORT;
                                    end
                                end
                            end
                        end
                        FN_WRITE_ORDER:
                        begin
                            if (item.channel_full)
                            begin
                                order_next             = item.channel_word;
                                res_next.channel_taken = 1'b1;
                                case (item.channel_word[11:8])
                                    ORD_SERVICE:  res_next.notify = NT_SERVICE;
                                    ORD_HIGH:     res_next.notify = NT_HIGH;
                                    ORD_LOW:      res_next.notify = NT_LOW;
                                    ORD_RETRY:    res_next.notify = NT_RETRY;
                                    ORD_REGULATION:
                                    begin
                                        res_next.notify           = NT_REGULATION;
                                        res_next.regulation_level = item.channel_word[7:0];
                                    end
                                    ORD_INIT_ACK: res_next.notify = NT_RETRY;
                                    default:      res_next.notify = NT_NONE;
                                endcase
                            end
                        end
                        FN_READ_ZERO:
                        begin
                            res_next.channel_out_valid = 1'b1;
                        end
                        FN_TAKE_A, FN_TAKE_B, FN_TAKE_C:
                        begin
                            res_next.channel_taken = item.channel_full;
                        end
                        default:
                        begin
                            res_next.channel_taken = 1'b0;
                        end
                    endcase
                end
                MODE_UPLINE:
                begin
                    if (proto_reg != PS_IDLE)
                    begin
                        res_next.status = ST_DECLINED;
                    end
                    else
                    begin
                        put_en = 1'b1;
                        if (item.upline_is_pru)
                        begin
                            put_val = NS_UL_PRU | {pru_cnt, 10'd0};
                        end
                        else if (item.upline_length <= SHORT_BLOCK)
                        begin
                            put_val = NS_UL_SHORT;
                        end
                        else
                        begin
                            put_val = NS_UL_LONG;
                        end
                        held_next    = 1'b1;
                        blk_len_next = CW'(item.upline_length);
                        proto_next   = PS_UPLINE;
                    end
                end
                MODE_DOWNLINE:
                begin
                    if (proto_reg != PS_IDLE)
                    begin
                        res_next.status = ST_DECLINED;
                    end
                    else if (!item.buffer_present)
                    begin
                        put_en          = 1'b1;
                        put_val         = NS_DL_NOBUF;
                        res_next.status = ST_DECLINED;
                    end
                    else
                    begin
                        put_en       = 1'b1;
                        put_val      = NS_DL_READY;
                        held_next    = 1'b1;
                        blk_len_next = '0;
                        proto_next   = PS_DOWNLINE;
                    end
                end
                MODE_TICK:
                begin
                    tick_next = tick_reg + 1'b1;
                end
                MODE_BUF_RD:
                begin
                    byte_buf_next = addr_ok;
                end
                default:
                begin
                    byte_buf_next = 1'b0;
                end
            endcase

            if (put_en)
            begin
                last_status_next = tick_reg;
                npu_status_next  = put_val;
                cpl_status_next  = cpl_status_next | STATUS_LOADED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proto_reg       <= PS_INIT;
            init_rem_reg    <= INIT_COUNT_RST;
            cpl_status_reg  <= '0;
            npu_status_reg  <= '0;
            order_reg       <= '0;
            active_fn_reg   <= FN_NONE;
            xfer_cnt_reg    <= '0;
            ptr_reg         <= '0;
            held_reg        <= 1'b0;
            tick_reg        <= '0;
            last_status_reg <= '0;
            blk_len_reg     <= '0;
            idle_ticks_reg  <= IDLE_TICKS_RST;
            init_count_reg  <= INIT_COUNT_RST;
            byte_chan_reg   <= 1'b0;
            byte_buf_reg    <= 1'b0;
        end
        else
        begin
            proto_reg       <= proto_next;
            init_rem_reg    <= init_rem_next;
            cpl_status_reg  <= cpl_status_next;
            npu_status_reg  <= npu_status_next;
            order_reg       <= order_next;
            active_fn_reg   <= active_fn_next;
            xfer_cnt_reg    <= xfer_cnt_next;
            ptr_reg         <= ptr_next;
            held_reg        <= held_next;
            tick_reg        <= tick_next;
            last_status_reg <= last_status_next;
            blk_len_reg     <= blk_len_next;
            byte_chan_reg   <= byte_chan_next;
            byte_buf_reg    <= byte_buf_next;
            if (cfg_we && cfg_index == CFG_IDLE_TICKS)
            begin
                idle_ticks_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_INIT_COUNT)
            begin
                init_count_reg <= cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result = res_reg;
endmodule
`default_nettype wire

### rtl/host_coupler_interface.sv
// Top level: host coupler interface, controller plus datapath.
// Usage:
//   items   - one event transaction per item (function, channel slot, offers,
//             tick, buffer-side write or read).
//   results - exactly one result transaction per item.
//   cfg     - register writes: index 0 idle announce gap, index 1 init report
//             count. Always ready; write only while no item is in flight.
// Timing: an item is taken only when the block is empty. Its result shows
//   in the cycle after acceptance, or after an extra fetch state when the
//   byte buffer is read (buffer read event, or an upline byte on a channel
//   slot), as the buffer RAM read is registered. No new item is taken until
//   the result of the last one has been taken on the result side.
// Stall: the result stays in its output register while results.ready is
//   low, and items.ready stays low until it is taken.
// Reset: rst_n asynchronous, active low. Protocol returns to init, status
//   words and counters clear, registers but the result register take their
//   defaults. The buffer content is undefined until written; no clearing pass.
`default_nettype none
module host_coupler_interface #(
    parameter int BUFFER_BYTES = 2048
) (
    input wire logic    clk,
    input wire logic    rst_n,
    hci_item_if.sink    items,
    hci_result_if.source results,
    hci_cfg_if.sink     cfg
);
    import hci_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg.ready = 1'b1;

    hci_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hci_dp #(.BUFFER_BYTES(BUFFER_BYTES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (items.payload),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .cmd       (cmd),
        .stat      (stat),
        .result    (results.payload)
    );
endmodule
`default_nettype wire

### test/tb_top.sv
// Testbench for host_coupler_interface: random and directed host events, checked against a local model.
`timescale 1ns / 1ps
module tb_top;
    import hci_pkg::*;

    localparam int BUF_BYTES = 2048;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        item_t   it;
        result_t res;
    } txn_t;

    logic clk;
    logic rst_n;

    hci_item_if   items ();
    hci_result_if results ();
    hci_cfg_if    cfg ();

    host_coupler_interface #(.BUFFER_BYTES(BUF_BYTES)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // model state
    proto_state_t ps;
    logic [3:0]   init_left;
    logic [11:0]  cpl_stat;
    logic [15:0]  npu_word;
    logic [11:0]  order_reg;
    logic [8:0]   act_fn;
    int unsigned  xfer_cnt;
    int unsigned  ptr;
    bit           held;
    logic [31:0]  ticks;
    logic [31:0]  last_stat_t;
    int unsigned  blk_len;
    logic [7:0]   buf_mem [BUF_BYTES];
    bit           wr_map [BUF_BYTES];
    logic [31:0]  gap_ticks;
    logic [3:0]   init_cnt;

    txn_t    pend_q [$];
    result_t due_q [$];
    result_t cur_due;
    bit      item_took;
    int      errors;
    int      gen_cnt;
    int      snd_pct;
    int      rcv_pct;
    int      cyc;

    function automatic void put_status(logic [15:0] v);
        last_stat_t = ticks;
        npu_word = v;
        cpl_stat = cpl_stat | STATUS_LOADED;
    endfunction

    function automatic void clear_hip();
        ps = PS_INIT;
        init_left = init_cnt;
        cpl_stat = '0;
        npu_word = '0;
        order_reg = '0;
        act_fn = FN_NONE;
        xfer_cnt = 0;
        ptr = 0;
        held = 1'b0;
        last_stat_t = '0;
        blk_len = 0;
    endfunction

    function automatic int unsigned pru_blocks(int unsigned l7, int unsigned ub);
        int unsigned total;
        int unsigned words;
        int unsigned p;
        total = l7 * 8;
        if (ub >= total)
            return 1;
        words = (total - ub + 59) / 60;
        p = (words + 63) / 64;
        if (p < 1)
            p = 1;
        if (p > 63)
            p = 63;
        return p;
    endfunction

    function automatic logic [1:0] run_function(logic [8:0] code);
        case (code)
            FN_READ_CPL:
            begin
                if (ps == PS_INIT)
                begin
                    if (init_left > 0)
                    begin
                        init_left = init_left - 4'd1;
                        put_status(NS_INIT_DONE);
                    end
                    else
                    begin
                        ps = PS_IDLE;
                        put_status(NS_IDLE);
                    end
                end
                else if (ps == PS_IDLE)
                begin
                    if ((ticks - last_stat_t) > gap_ticks)
                        put_status(NS_IDLE);
                end
            end
            FN_INPUT_DATA, FN_OUTPUT_DATA:
            begin
                if (!held)
                begin
                    ps = PS_IDLE;
                    xfer_cnt = 0;
                    act_fn = FN_NONE;
                    return ST_DECLINED;
                end
                ptr = 0;
                xfer_cnt = (code == FN_INPUT_DATA) ? blk_len : 0;
            end
            FN_READ_NPU, FN_READ_ORDER, FN_READ_ZERO, FN_TAKE_A, FN_TAKE_B, FN_TAKE_C: ;
            FN_WRITE_ORDER:
            begin
                ps = PS_IDLE;
                put_status(NS_IDLE);
            end
            FN_CLEAR: clear_hip();
            FN_SEL_A, FN_SEL_B, FN_SEL_C: return ST_NO_SEL;
            default: return ST_DECLINED;
        endcase
        act_fn = code;
        return ST_ACCEPTED;
    endfunction

    function automatic void bump_ptr();
        ptr = (ptr + 1 >= BUF_BYTES) ? 0 : ptr + 1;
    endfunction

    function automatic result_t hip_step(item_t it);
        result_t r;
        r = '0;
        case (it.mode)
            MODE_FUNCTION: r.status = run_function(it.func_code[8:0]);
            MODE_CHANNEL:
            begin
                case (act_fn)
                    FN_READ_NPU:
                    begin
                        r.channel_out = npu_word;
                        r.channel_out_valid = 1'b1;
                        cpl_stat = cpl_stat & ~STATUS_LOADED;
                        npu_word = '0;
                    end
                    FN_READ_CPL:
                    begin
                        r.channel_out = {4'b0, cpl_stat};
                        r.channel_out_valid = 1'b1;
                    end
                    FN_READ_ORDER:
                    begin
                        r.channel_out = {4'b0, order_reg};
                        r.channel_out_valid = 1'b1;
                    end
                    FN_INPUT_DATA:
                    begin
                        if (!it.channel_full && xfer_cnt > 0)
                        begin
                            r.channel_out = {8'b0, buf_mem[ptr]};
                            r.channel_out_valid = 1'b1;
                            bump_ptr();
                            xfer_cnt--;
                            if (xfer_cnt == 0)
                            begin
                                r.channel_out = r.channel_out | LAST_BYTE_MARK;
                                r.disconnect_after = 1'b1;
                                act_fn = FN_NONE;
                                ps = PS_IDLE;
                                r.notify = NT_UPLINE;
                            end
                        end
                    end
                    FN_OUTPUT_DATA:
                    begin
                        if (it.channel_full)
                        begin
                            r.channel_taken = 1'b1;
                            if (xfer_cnt < BUF_BYTES)
                            begin
                                buf_mem[ptr] = it.channel_word[7:0];
                                wr_map[ptr] = 1'b1;
                                bump_ptr();
                                xfer_cnt++;
                                if (it.channel_word[11])
                                begin
                                    blk_len = xfer_cnt;
                                    act_fn = FN_NONE;
                                    ps = PS_IDLE;
                                    r.notify = NT_DL_DONE;
                                    r.downline_length = xfer_cnt[11:0];
                                end
                                else if (xfer_cnt >= BUF_BYTES)
                                begin
                                    act_fn = FN_NONE;
                                    ps = PS_IDLE;
                                    r.notify = NT_DL_ABORT;
                                end
                            end
                        end
                    end
                    FN_WRITE_ORDER:
                    begin
                        if (it.channel_full)
                        begin
                            order_reg = it.channel_word;
                            r.channel_taken = 1'b1;
                            case (it.channel_word[11:8])
                                ORD_SERVICE:  r.notify = NT_SERVICE;
                                ORD_HIGH:     r.notify = NT_HIGH;
                                ORD_LOW:      r.notify = NT_LOW;
                                ORD_RETRY:    r.notify = NT_RETRY;
                                ORD_REGULATION:
                                begin
                                    r.notify = NT_REGULATION;
                                    r.regulation_level = it.channel_word[7:0];
                                end
                                ORD_INIT_ACK: r.notify = NT_RETRY;
                                default: ;
                            endcase
                        end
                    end
                    FN_READ_ZERO: r.channel_out_valid = 1'b1;
                    FN_TAKE_A, FN_TAKE_B, FN_TAKE_C: r.channel_taken = it.channel_full;
                    default: ;
                endcase
            end
            MODE_UPLINE:
            begin
                if (ps != PS_IDLE)
                    r.status = ST_DECLINED;
                else
                begin
                    if (it.upline_is_pru)
                        put_status(NS_UL_PRU | 16'(pru_blocks(it.level7_length,
                            it.unused_bits) << 10));
                    else if (it.upline_length <= SHORT_BLOCK)
                        put_status(NS_UL_SHORT);
                    else
                        put_status(NS_UL_LONG);
                    held = 1'b1;
                    blk_len = it.upline_length;
                    ps = PS_UPLINE;
                end
            end
            MODE_DOWNLINE:
            begin
                if (ps != PS_IDLE)
                    r.status = ST_DECLINED;
                else if (!it.buffer_present)
                begin
                    put_status(NS_DL_NOBUF);
                    r.status = ST_DECLINED;
                end
                else
                begin
                    put_status(NS_DL_READY);
                    held = 1'b1;
                    blk_len = 0;
                    ps = PS_DOWNLINE;
                end
            end
            MODE_TICK: ticks = ticks + 1;
            MODE_BUF_WR:
            begin
                buf_mem[it.buffer_address] = it.buffer_data;
                wr_map[it.buffer_address] = 1'b1;
            end
            MODE_BUF_RD: r.buffer_byte = buf_mem[it.buffer_address];
            default: ;
        endcase
        return r;
    endfunction

    // queue one event; never read a byte that was not written
    task automatic send(item_t it);
        txn_t t;
        if (it.mode == MODE_BUF_RD && !wr_map[it.buffer_address])
            it.mode = MODE_BUF_WR;
        if (it.mode == MODE_CHANNEL && act_fn == FN_INPUT_DATA && !it.channel_full
            && xfer_cnt > 0 && !wr_map[ptr])
            it.channel_full = 1'b1;
        t.it = it;
        t.res = hip_step(it);
        pend_q.push_back(t);
        gen_cnt++;
    endtask

    function automatic item_t noise_item();
        item_t it;
        it = item_t'(85'({$urandom, $urandom, $urandom}));
        it.mode = 3'($urandom_range(7));
        if (it.upline_length > 2048)
            it.upline_length = 12'($urandom_range(2048));
        return it;
    endfunction

    task automatic fn(logic [8:0] code);
        item_t it;
        it = noise_item();
        it.mode = MODE_FUNCTION;
        it.func_code = {3'($urandom), code};
        send(it);
    endtask

    task automatic slot(bit full, logic [11:0] word);
        item_t it;
        it = noise_item();
        it.mode = MODE_CHANNEL;
        it.channel_full = full;
        it.channel_word = word;
        send(it);
    endtask

    task automatic go_idle();
        if (ps != PS_IDLE)
        begin
            fn(FN_WRITE_ORDER);
            slot(1'b1, 12'($urandom));
        end
    endtask

    task automatic upline_seq(int n, bit pru, int l7, int ub);
        item_t it;
        for (int i = 0; i < n; i++)
        begin
            it = noise_item();
            it.mode = MODE_BUF_WR;
            it.buffer_address = 11'(i);
            send(it);
        end
        go_idle();
        it = noise_item();
        it.mode = MODE_UPLINE;
        it.upline_length = 12'(n);
        it.upline_is_pru = pru;
        it.level7_length = 16'(l7);
        it.unused_bits = 8'(ub);
        send(it);
        fn(FN_READ_NPU);
        slot(1'b0, '0);
        fn(FN_INPUT_DATA);
        for (int i = 0; i < n; i++)
            slot($urandom_range(9) == 0, 12'($urandom));
    endtask

    // offer a non-PRU upline block and read back the status only
    task automatic upline_offer(int len);
        item_t it;
        go_idle();
        it = noise_item();
        it.mode = MODE_UPLINE;
        it.upline_length = 12'(len);
        it.upline_is_pru = 1'b0;
        send(it);
        fn(FN_READ_NPU);
        slot(1'b0, '0);
    endtask

    task automatic downline_seq(int n, bit present);
        item_t it;
        go_idle();
        it = noise_item();
        it.mode = MODE_DOWNLINE;
        it.buffer_present = present;
        send(it);
        fn(FN_OUTPUT_DATA);
        for (int i = 0; i < n; i++)
            slot($urandom_range(11) != 0, {1'b0, 11'($urandom)});
        slot(1'b1, {1'b1, 11'($urandom)});
    endtask

    task automatic random_items(int n);
        int pick;
        int stop;
        stop = gen_cnt + n;
        while (gen_cnt < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                upline_seq(($urandom_range(15) == 0) ? $urandom_range(257, 400)
                    : $urandom_range(1, 12), $urandom_range(1), $urandom, $urandom);
            else if (pick < 65)
                downline_seq($urandom_range(12), $urandom_range(7) != 0);
            else if (pick < 75)
            begin
                fn(FN_READ_CPL);
                repeat ($urandom_range(1, 4))
                    slot(1'b0, '0);
                repeat ($urandom_range(3))
                    fn(FN_READ_CPL);
            end
            else if (pick < 82)
            begin
                fn(9'($urandom));
                repeat ($urandom_range(1, 3))
                    slot($urandom_range(1), 12'($urandom));
            end
            else
                repeat ($urandom_range(1, 5))
                    send(noise_item());
        end
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || items.valid || due_q.size() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (idx == CFG_IDLE_TICKS)
            gap_ticks = val;
        else
            init_cnt = val[3:0];
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic report(string field, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    task automatic check_result(result_t got, result_t want);
        if (got.status !== want.status)
            report("status", 16'(got.status), 16'(want.status));
        if (got.channel_out !== want.channel_out)
            report("channel_out", got.channel_out, want.channel_out);
        if (got.channel_out_valid !== want.channel_out_valid)
            report("channel_out_valid", 16'(got.channel_out_valid), 16'(want.channel_out_valid));
        if (got.channel_taken !== want.channel_taken)
            report("channel_taken", 16'(got.channel_taken), 16'(want.channel_taken));
        if (got.disconnect_after !== want.disconnect_after)
            report("disconnect_after", 16'(got.disconnect_after), 16'(want.disconnect_after));
        if (got.notify !== want.notify)
            report("notify", 16'(got.notify), 16'(want.notify));
        if (got.regulation_level !== want.regulation_level)
            report("regulation_level", 16'(got.regulation_level), 16'(want.regulation_level));
        if (got.downline_length !== want.downline_length)
            report("downline_length", 16'(got.downline_length), 16'(want.downline_length));
        if (got.buffer_byte !== want.buffer_byte)
            report("buffer_byte", 16'(got.buffer_byte), 16'(want.buffer_byte));
    endtask

    always @(negedge clk)
    begin : drv
        txn_t t;
        if (!rst_n)
            items.valid <= 1'b0;
        else if (!items.valid || item_took)
        begin
            if (pend_q.size() > 0 && $urandom_range(99) >= snd_pct)
            begin
                t = pend_q.pop_front();
                items.valid <= 1'b1;
                items.payload <= t.it;
                cur_due <= t.res;
            end
            else
                items.valid <= 1'b0;
        end
        results.ready <= rst_n && ($urandom_range(99) >= rcv_pct);
    end

    always @(posedge clk)
    begin : mon
        result_t want;
        item_took <= items.valid && items.ready;
        if (rst_n)
        begin
            if (items.valid && items.ready)
                due_q.push_back(cur_due);
            if (results.valid && results.ready)
            begin
                if (due_q.size() == 0)
                begin
                    $display("unexpected result transaction at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    want = due_q.pop_front();
                    check_result(results.payload, want);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        item_t it;
        rst_n = 1'b0;
        items.valid = 1'b0;
        items.payload = '0;
        results.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        item_took = 1'b0;
        cur_due = '0;
        errors = 0;
        gen_cnt = 0;
        cyc = 0;
        snd_pct = 30;
        rcv_pct = 64;
        gap_ticks = IDLE_TICKS_RST;
        init_cnt = INIT_COUNT_RST;
        ticks = '0;
        clear_hip();
        foreach (wr_map[i])
            wr_map[i] = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: refusals in init, decline cases, unknown codes, extremes
        fn(FN_INPUT_DATA);
        it = noise_item();
        it.mode = MODE_UPLINE;
        send(it);
        fn(9'o777);
        fn(FN_SEL_A);
        fn(FN_SEL_B);
        fn(FN_SEL_C);
        it = noise_item();
        it.mode = 3'd7;
        send(it);
        it.mode = MODE_TICK;
        send(it);
        it.mode = MODE_BUF_WR;
        it.buffer_address = 11'h7FF;
        it.buffer_data = 8'hFF;
        send(it);
        it.mode = MODE_BUF_RD;
        send(it);
        repeat (5)
            fn(FN_READ_CPL);
        slot(1'b0, '0);
        it = noise_item();
        it.mode = MODE_DOWNLINE;
        it.buffer_present = 1'b0;
        send(it);
        upline_seq(1, 1'b1, 0, 255);
        upline_seq(2, 1'b1, 65535, 0);
        upline_seq(0, 1'b0, 0, 0);
        fn(FN_WRITE_ORDER);
        for (int k = 0; k < 8; k++)
            slot(1'b1, {4'(k), 8'($urandom)});
        fn(FN_CLEAR);
        random_items(330);
        drain();

        write_reg(CFG_IDLE_TICKS, 32'd1);
        write_reg(CFG_INIT_COUNT, 4'd0);
        fn(FN_CLEAR);
        upline_offer(256);
        upline_offer(257);
        random_items(280);
        drain();

        snd_pct = 64;
        rcv_pct = 30;
        write_reg(CFG_IDLE_TICKS, 32'hFFFF_FFFF);
        write_reg(CFG_INIT_COUNT, 4'd15);
        fn(FN_CLEAR);
        random_items(230);
        drain();

        snd_pct = 0;
        rcv_pct = 0;
        write_reg(CFG_IDLE_TICKS, 32'd3);
        write_reg(CFG_INIT_COUNT, 4'd2);
        fn(FN_CLEAR);
        downline_seq(20, 1'b1);
        random_items(180);
        drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### host_coupler_interface.f
rtl/hci_pkg.sv
rtl/hci_if.sv
rtl/hci_ram.sv
rtl/hci_ctrl.sv
rtl/hci_dp.sv
rtl/host_coupler_interface.sv
test/tb_top.sv
